### rtl/tlbe_pkg.sv
// Shared types and constants for the tree leaf box extractor.
// Used by every module under rtl/; depends on nothing.
package tlbe_pkg;

  // Default sizes
  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned MaxDepthDef = 16;
  localparam int unsigned FeaturesDef = 16;

  // Operation codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TREE_CLASS = 1'b0;
  localparam logic CFG_FIRST_LEAF = 1'b1;

  // One stored tree node
  typedef struct packed {
    logic [9:0]         left;
    logic [9:0]         right;
    logic               leaf;
    logic signed [31:0] split;
    logic [3:0]         feat;
    logic signed [31:0] score;
  } node_t;

  // Control from the sequencer to the bounds unit
  typedef struct packed {
    logic clear;
    logic upd;
    logic shift;
  } bnd_ctrl_t;

endpackage

### rtl/tlbe_node_mem.sv
// Node table memory: one write port, one read port with registered data.
// Depends on tlbe_pkg (node_t).
module tlbe_node_mem #(
  parameter int unsigned Depth = tlbe_pkg::MaxNodesDef,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tlbe_pkg::node_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output tlbe_pkg::node_t rdata_o
);

  tlbe_pkg::node_t mem [Depth];
  tlbe_pkg::node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tlbe_bounds.sv
// Per-feature box bounds: one shared signed comparator folds one path level
// per cycle; results leave through entry 0 of a shift line.
// Depends on tlbe_pkg (bnd_ctrl_t).
module tlbe_bounds #(
  parameter int unsigned Features = tlbe_pkg::FeaturesDef,
  localparam int unsigned KW      = (Features > 1) ? $clog2(Features) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbe_pkg::bnd_ctrl_t ctrl_i,
  input  logic [3:0]          feat_i,
  input  logic signed [31:0]  split_i,
  input  logic                left_i,
  output logic signed [31:0]  lo_o,
  output logic signed [31:0]  hi_o,
  output logic                lo_ok_o,
  output logic                hi_ok_o
);

  logic signed [31:0] lo_q [Features];
  logic signed [31:0] hi_q [Features];
  logic [Features-1:0] lo_ok_q, hi_ok_q;

  logic [KW-1:0]      idx;
  logic               feat_ok;
  logic signed [31:0] cur;
  logic               cur_ok;
  logic               better;

  // shared compare against the bound this level touches
  always_comb begin
    idx     = KW'(feat_i);
    feat_ok = 32'(feat_i) < Features;
    cur     = left_i ? hi_q[idx] : lo_q[idx];
    cur_ok  = left_i ? hi_ok_q[idx] : lo_ok_q[idx];
    better  = left_i ? (split_i < cur) : (split_i > cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_ok_q <= '0;
      hi_ok_q <= '0;
      for (int i = 0; i < Features; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      lo_ok_q <= '0;
      hi_ok_q <= '0;
      for (int i = 0; i < Features; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (ctrl_i.upd) begin
      if (feat_ok && (!cur_ok || better)) begin
        if (left_i) begin
          hi_q[idx]    <= split_i;
          hi_ok_q[idx] <= 1'b1;
        end else begin
          lo_q[idx]    <= split_i;
          lo_ok_q[idx] <= 1'b1;
        end
      end
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < Features - 1; i++) begin
        lo_q[i] <= lo_q[i+1];
        hi_q[i] <= hi_q[i+1];
      end
      lo_q[Features-1] <= '0;
      hi_q[Features-1] <= '0;
      lo_ok_q <= lo_ok_q >> 1;
      hi_ok_q <= hi_ok_q >> 1;
    end
  end

  assign lo_o    = lo_q[0];
  assign hi_o    = hi_q[0];
  assign lo_ok_o = lo_ok_q[0];
  assign hi_ok_o = hi_ok_q[0];

endmodule

### rtl/tree_leaf_box_extractor_core.sv
// Top level of the tree leaf box extractor: sequencer, walk stack, path store.
// Depends on tlbe_pkg, tlbe_node_mem and tlbe_bounds.
//
//   channel | direction | handshake                  | word
//   in      | input     | in_valid_i / in_stall_o    | operation + node fields
//   out     | output    | out_valid_o / out_stall_i  | one box interval or done
//   cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// A next-leaf request pops nodes from the walk stack and reads each one from
// the node table (stack pop plus node table read), then folds the path levels
// of the leaf it reaches in the bound unit, then emits Features output words.
// An unarmed walk answers with one done word directly; a finished walk answers
// after a pop that finds the stack empty.
// Reset empties the stack and disarms the walk; the node table is not cleared.
// Out stalls hold the output register and hold the sequencer in its emit or done state.
module tree_leaf_box_extractor_core #(
  parameter int unsigned NODE_SLOTS = tlbe_pkg::MaxNodesDef,
  parameter int unsigned DEPTH_CAP  = tlbe_pkg::MaxDepthDef,
  parameter int unsigned FEATURES   = tlbe_pkg::FeaturesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [9:0]         node_index_i,
  input  logic [9:0]         left_child_i,
  input  logic [9:0]         right_child_i,
  input  logic               is_leaf_i,
  input  logic signed [31:0] split_value_i,
  input  logic [3:0]         split_feature_i,
  input  logic signed [31:0] node_score_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        leaf_number_o,
  output logic [3:0]         feature_o,
  output logic signed [31:0] lower_bound_o,
  output logic signed [31:0] upper_bound_o,
  output logic               lower_bounded_o,
  output logic               upper_bounded_o,
  output logic [7:0]         leaf_class_o,
  output logic signed [31:0] leaf_score_o,
  output logic               last_of_leaf_o,
  output logic               walk_done_o
);

  localparam int unsigned AW  = $clog2(NODE_SLOTS);
  localparam int unsigned DW  = $clog2(DEPTH_CAP + 1);
  localparam int unsigned SC  = DEPTH_CAP + 1;
  localparam int unsigned IW  = $clog2(SC);
  localparam int unsigned SPW = $clog2(SC + 1);
  localparam int unsigned KW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [7:0]  tree_class_q;
  logic [15:0] first_leaf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_class_q <= '0;
      first_leaf_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlbe_pkg::CFG_TREE_CLASS: tree_class_q <= cfg_data_i[7:0];
        tlbe_pkg::CFG_FIRST_LEAF: first_leaf_q <= cfg_data_i;
      endcase
    end
  end

  // walk state
  logic [9:0]     stk_node  [SC];
  logic [DW-1:0]  stk_depth [SC];
  logic [SC-1:0]  stk_left;
  logic [SPW-1:0] sp_q, sp_d;

  logic [3:0]         path_feat  [SC];
  logic signed [31:0] path_split [SC];
  logic [SC-1:0]      path_left;

  logic          armed_q;
  logic [15:0]   leaves_q;
  logic [DW-1:0] cur_depth_q;
  logic          cur_inr_q;
  logic [DW-1:0] scan_q;
  logic [KW-1:0] k_q;
  logic signed [31:0] score_q;

  // output register
  logic               ov_q;
  logic [15:0]        o_num_q;
  logic [3:0]         o_feat_q;
  logic signed [31:0] o_lo_q, o_hi_q, o_score_q;
  logic               o_lok_q, o_hok_q, o_last_q, o_done_q;
  logic [7:0]         o_class_q;

  logic in_acc, out_free;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // node table
  logic            wr_inr;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  tlbe_pkg::node_t mem_wdata, mem_rdata;
  logic [IW-1:0]   top_ix;
  logic [9:0]      top_node;
  logic            top_inr;

  assign wr_inr    = 32'(node_index_i) < NODE_SLOTS;
  assign mem_waddr = AW'(node_index_i);
  assign mem_wdata = '{left: left_child_i, right: right_child_i, leaf: is_leaf_i,
                       split: split_value_i, feat: split_feature_i,
                       score: node_score_i};
  assign top_ix    = IW'(sp_q - SPW'(1));
  assign top_node  = stk_node[top_ix];
  assign top_inr   = 32'(top_node) < NODE_SLOTS;
  assign mem_raddr = AW'(top_node);

  tlbe_node_mem #(.Depth(NODE_SLOTS)) u_mem (
    .clk_i,
    .we_i    (in_acc && operation_i == tlbe_pkg::OP_LOAD && wr_inr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // fetched node, out-of-range slots read as a blank leaf
  logic  nd_leaf;
  logic  stop;
  assign nd_leaf = !cur_inr_q || mem_rdata.leaf;
  assign stop    = nd_leaf || (32'(cur_depth_q) >= DEPTH_CAP);

  // bounds unit
  tlbe_pkg::bnd_ctrl_t bctl;
  logic signed [31:0]  b_lo, b_hi;
  logic                b_lok, b_hok;
  logic [DW-1:0]       scan_nx;
  assign scan_nx = DW'(scan_q + DW'(1));

  assign bctl.clear = (state_q == S_FETCH) && stop;
  assign bctl.upd   = (state_q == S_SCAN) && (scan_q != cur_depth_q);
  assign bctl.shift = (state_q == S_EMIT) && out_free;

  tlbe_bounds #(.Features(FEATURES)) u_bnd (
    .clk_i,
    .rst_ni,
    .ctrl_i  (bctl),
    .feat_i  (path_feat[scan_q]),
    .split_i (path_split[scan_q]),
    .left_i  (path_left[scan_nx]),
    .lo_o    (b_lo),
    .hi_o    (b_hi),
    .lo_ok_o (b_lok),
    .hi_ok_o (b_hok)
  );

  // saturating leaf number
  logic [16:0] num_sum;
  logic [15:0] num_sat;
  assign num_sum = 17'(first_leaf_q) + 17'(leaves_q);
  assign num_sat = num_sum[16] ? 16'hFFFF : num_sum[15:0];

  logic emit_last;
  assign emit_last = 32'(k_q) == FEATURES - 1;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i == tlbe_pkg::OP_NEXT) begin
          state_d = armed_q ? S_POP : S_DONE;
        end
      end
      S_POP:   state_d = (sp_q == '0) ? S_DONE : S_FETCH;
      S_FETCH: state_d = stop ? S_SCAN : S_POP;
      S_SCAN:  state_d = (scan_q == cur_depth_q) ? S_EMIT : S_SCAN;
      S_EMIT:  state_d = (out_free && emit_last) ? S_IDLE : S_EMIT;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // stack pointer
  always_comb begin
    sp_d = sp_q;
    if (in_acc && operation_i == tlbe_pkg::OP_LOAD) begin
      sp_d = SPW'(1);
    end else if (state_q == S_POP && sp_q != '0) begin
      sp_d = SPW'(sp_q - SPW'(1));
    end else if (state_q == S_FETCH && !stop) begin
      if (32'(sp_q) + 2 <= SC) begin
        sp_d = SPW'(sp_q + SPW'(2));
      end else if (32'(sp_q) < SC) begin
        sp_d = SPW'(sp_q + SPW'(1));
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sp_q     <= '0;
      armed_q  <= 1'b0;
      leaves_q <= '0;
      ov_q     <= 1'b0;
      scan_q   <= '0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (in_acc && operation_i == tlbe_pkg::OP_LOAD) begin
        armed_q  <= 1'b1;
        leaves_q <= '0;
      end
      if (state_q == S_DONE && out_free) begin
        armed_q <= 1'b0;
      end
      if (state_q == S_FETCH) begin
        scan_q <= '0;
      end else if (bctl.upd) begin
        scan_q <= scan_nx;
      end
      if (state_q == S_SCAN) begin
        k_q <= '0;
      end else if (bctl.shift) begin
        k_q <= KW'(k_q + KW'(1));
        if (emit_last && leaves_q != 16'hFFFF) begin
          leaves_q <= leaves_q + 16'd1;
        end
      end
      // output valid
      if ((state_q == S_EMIT || state_q == S_DONE) && out_free) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // walk stack, path store and per-node payload
  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == tlbe_pkg::OP_LOAD) begin
      stk_node[0]  <= '0;
      stk_depth[0] <= '0;
      stk_left[0]  <= 1'b0;
    end
    if (state_q == S_POP && sp_q != '0) begin
      path_left[stk_depth[top_ix]] <= stk_left[top_ix];
      cur_depth_q                  <= stk_depth[top_ix];
      cur_inr_q                    <= top_inr;
    end
    if (state_q == S_FETCH) begin
      if (stop) begin
        score_q <= cur_inr_q ? mem_rdata.score : '0;
      end else begin
        path_feat[cur_depth_q]  <= mem_rdata.feat;
        path_split[cur_depth_q] <= mem_rdata.split;
        if (32'(sp_q) < SC) begin
          stk_node[IW'(sp_q)]  <= mem_rdata.right;
          stk_depth[IW'(sp_q)] <= DW'(cur_depth_q + DW'(1));
          stk_left[IW'(sp_q)]  <= 1'b0;
        end
        if (32'(sp_q) + 1 < SC) begin
          stk_node[IW'(sp_q + SPW'(1))]  <= mem_rdata.left;
          stk_depth[IW'(sp_q + SPW'(1))] <= DW'(cur_depth_q + DW'(1));
          stk_left[IW'(sp_q + SPW'(1))]  <= 1'b1;
        end
      end
    end
    // output word
    if (state_q == S_EMIT && out_free) begin
      o_num_q   <= num_sat;
      o_feat_q  <= 4'(k_q);
      o_lo_q    <= b_lo;
      o_hi_q    <= b_hi;
      o_lok_q   <= b_lok;
      o_hok_q   <= b_hok;
      o_class_q <= tree_class_q;
      o_score_q <= score_q;
      o_last_q  <= emit_last;
      o_done_q  <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      o_num_q   <= '0;
      o_feat_q  <= '0;
      o_lo_q    <= '0;
      o_hi_q    <= '0;
      o_lok_q   <= 1'b0;
      o_hok_q   <= 1'b0;
      o_class_q <= '0;
      o_score_q <= '0;
      o_last_q  <= 1'b0;
      o_done_q  <= 1'b1;
    end
  end

  assign out_valid_o     = ov_q;
  assign leaf_number_o   = o_num_q;
  assign feature_o       = o_feat_q;
  assign lower_bound_o   = o_lo_q;
  assign upper_bound_o   = o_hi_q;
  assign lower_bounded_o = o_lok_q;
  assign upper_bounded_o = o_hok_q;
  assign leaf_class_o    = o_class_q;
  assign leaf_score_o    = o_score_q;
  assign last_of_leaf_o  = o_last_q;
  assign walk_done_o     = o_done_q;

endmodule

### rtl/tlbe_checker.sv
// Port-level checks for the tree leaf box extractor, bound to the top level.
// Depends on tree_leaf_box_extractor_core port names.
module tlbe_checker #(
  parameter int unsigned FEATURES = tlbe_pkg::FeaturesDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        leaf_number_o,
  input logic [3:0]         feature_o,
  input logic signed [31:0] lower_bound_o,
  input logic signed [31:0] upper_bound_o,
  input logic               lower_bounded_o,
  input logic               upper_bounded_o,
  input logic [7:0]         leaf_class_o,
  input logic signed [31:0] leaf_score_o,
  input logic               last_of_leaf_o,
  input logic               walk_done_o
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lower_bound_o)
      && $stable(feature_o) && $stable(walk_done_o))
    else $error("output word changed under stall");

  // done word carries nothing else
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && walk_done_o |-> leaf_number_o == 16'd0 && leaf_score_o == 32'sd0
      && !lower_bounded_o && !upper_bounded_o && !last_of_leaf_o && leaf_class_o == 8'd0)
    else $error("done word has payload");

  // unbounded side reads zero
  a_unbounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!lower_bounded_o || !upper_bounded_o) |->
      (lower_bounded_o || lower_bound_o == 32'sd0) &&
      (upper_bounded_o || upper_bound_o == 32'sd0))
    else $error("unbounded side not zero");

  // last word of a leaf is the last feature
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_leaf_o |-> feature_o == 4'(FEATURES - 1))
    else $error("last_of_leaf on wrong feature");

endmodule

bind tree_leaf_box_extractor_core tlbe_checker #(.FEATURES(FEATURES)) u_tlbe_checker (.*);
